### rtl/acpa_pkg.sv
package acpa_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int MAG_W        = 15;
    localparam int AVG_W        = 7;
    localparam int RESYNC_W     = 24;
    localparam int CFG_DATA_W   = 24;
    localparam int CFG_IDX_W    = 1;

    localparam int HISTORY_DEPTH = 122;
    localparam int DELAY_W       = $clog2(HISTORY_DEPTH);

    // signed width for the delay arithmetic; holds every value at the default window length
    localparam int DCALC_W = 10;

    localparam logic [CFG_IDX_W-1:0] REG_AVG_COUNT       = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESYNC_INTERVAL = 1'd1;

    localparam logic [AVG_W-1:0]    AVG_COUNT_RESET       = 7'd10;
    localparam logic [RESYNC_W-1:0] RESYNC_INTERVAL_RESET = 24'd100000;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

### rtl/acpa_if.sv
interface acpa_in_if
    import acpa_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       clock_level;

    modport source (output valid, output sample, output clock_level, input ready);
    modport sink   (input valid, input sample, input clock_level, output ready);
endinterface

interface acpa_out_if
    import acpa_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [MAG_W-1:0]   magnitude;
    logic               aligned_clock;
    logic               locked;
    logic [DELAY_W-1:0] clock_delay;

    modport source (output valid, output magnitude, output aligned_clock, output locked,
                    output clock_delay, input ready);
    modport sink   (input valid, input magnitude, input aligned_clock, input locked,
                    input clock_delay, output ready);
endinterface

### rtl/acpa_div.sv
module acpa_div
    import acpa_pkg::*;
#(
    parameter int N_W = 14,
    parameter int D_W = 7
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N_W-1:0] dividend,
    input  logic [D_W-1:0] divisor,
    output logic [N_W-1:0] quotient,
    output div_status_t    status
);

    localparam int CW = $clog2(N_W + 1);

    logic [D_W-1:0] rem_reg, rem_next;
    logic [N_W-1:0] quo_reg, quo_next;
    logic [D_W-1:0] div_reg, div_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           done_reg, done_next;

    logic [D_W:0]   trial;
    logic [D_W:0]   trial_sub;
    logic           fits;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        trial     = {rem_reg, quo_reg[N_W-1]};
        fits      = trial >= {1'b0, div_reg};
        trial_sub = trial - {1'b0, div_reg};

        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;

        if (start)
        begin
            rem_next = '0;
            quo_next = dividend;
            div_next = divisor;
            cnt_next = CW'(N_W);
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = fits ? trial_sub[D_W-1:0] : trial[D_W-1:0];
            quo_next  = {quo_reg[N_W-2:0], fits};
            cnt_next  = cnt_reg - CW'(1);
            done_next = (cnt_reg == CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign quotient    = quo_reg;
    assign status.busy = (cnt_reg != '0);
    assign status.done = done_reg;

endmodule

### rtl/argmax_clock_phase_aligner_top.sv
// Clock phase aligner. Each sample word yields one result word: the saturated
// magnitude, the reference clock delayed by the current offset, the lock flag
// and the offset itself. While unlocked the block finds, per window of
// WINDOW_LEN samples, the position of the largest magnitude (ties to the later
// sample) and the position of the last clock edge; after avg_count windows it
// averages the peak positions, sets the delay and locks, then drops the lock
// after resync_interval locked samples. A sample passes accept, update and the
// output register, held while a result word stalls; one that closes the
// averaging also passes the divider start, the wait for the bit-serial divider
// that forms the average, and the delay update. The result register frees the
// input side while a word waits to be taken. No clearing pass after reset.
module argmax_clock_phase_aligner_top
    import acpa_pkg::*;
#(
    parameter int WINDOW_LEN   = 112,
    parameter int MAX_AVERAGED = 100
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    acpa_in_if.sink               sample_ch,
    acpa_out_if.source            result_ch
);

    localparam int CNT_W = $clog2(WINDOW_LEN + 1);
    localparam int POS_W = $clog2(WINDOW_LEN);
    localparam int WD_W  = $clog2(MAX_AVERAGED + 1);
    localparam int SUM_W = $clog2(MAX_AVERAGED * (WINDOW_LEN - 1) + 1);

    localparam logic [CNT_W-1:0] WIN_END = CNT_W'(WINDOW_LEN);
    localparam logic [AVG_W-1:0] AVG_MAX = AVG_W'(MAX_AVERAGED);
    localparam logic signed [DCALC_W-1:0] W_S    = DCALC_W'(WINDOW_LEN);
    localparam logic signed [DCALC_W-1:0] HALF_S = DCALC_W'(WINDOW_LEN / 2);
    localparam logic signed [DCALC_W-1:0] DMAX_S = DCALC_W'(HISTORY_DEPTH - 1);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_CALC   = 6'b000010,
        S_DSTART = 6'b000100,
        S_DWAIT  = 6'b001000,
        S_DELAY  = 6'b010000,
        S_OUT    = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [AVG_W-1:0]    avg_count_reg;
    logic [RESYNC_W-1:0] resync_interval_reg;

    logic                       synced_reg, synced_next;
    logic [CNT_W-1:0]           window_count_reg, window_count_next;
    logic [WD_W-1:0]            windows_done_reg, windows_done_next;
    logic [MAG_W-1:0]           window_peak_reg, window_peak_next;
    logic [POS_W-1:0]           peak_pos_reg, peak_pos_next;
    logic [SUM_W-1:0]           position_sum_reg, position_sum_next;
    logic [CNT_W-1:0]           edge_pos_reg, edge_pos_next;
    logic [DELAY_W-1:0]         delay_reg, delay_next;
    logic [RESYNC_W-1:0]        resync_count_reg, resync_count_next;
    logic [HISTORY_DEPTH-1:0]   history_reg, history_next;

    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                       level_reg;
    logic [MAG_W-1:0]           mag_reg, mag_next;

    logic                       out_valid_reg, out_valid_next;
    logic [MAG_W-1:0]           out_mag_reg;
    logic                       out_clk_reg;
    logic                       out_locked_reg;
    logic [DELAY_W-1:0]         out_delay_reg;

    logic                       in_take;
    logic                       out_load;
    logic                       div_start;
    logic [SUM_W-1:0]           div_quo;
    div_status_t                div_status;

    logic [SAMPLE_W-1:0]        neg_sample;
    logic [MAG_W-1:0]           mag_c;
    logic [AVG_W-1:0]           eff_count;
    logic                       lock_c;
    logic [RESYNC_W:0]          resync_inc;

    logic signed [DCALC_W-1:0]  avg_s, e_s, diff_s, abs_s, d_s;

    acpa_div #(
        .N_W (SUM_W),
        .D_W (WD_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (position_sum_reg),
        .divisor  (windows_done_reg),
        .quotient (div_quo),
        .status   (div_status)
    );

    assign sample_ch.ready = (state_reg == S_IDLE);
    assign in_take         = sample_ch.valid && sample_ch.ready;
    assign div_start       = (state_reg == S_DSTART);
    assign out_load        = (state_reg == S_OUT) && (!out_valid_reg || result_ch.ready);

    // magnitude with saturation of the most negative code
    always_comb
    begin
        neg_sample = 16'(~sample_reg + 16'sd1);
        if (sample_reg == 16'sh8000)
            mag_c = '1;
        else if (sample_reg[SAMPLE_W-1])
            mag_c = neg_sample[MAG_W-1:0];
        else
            mag_c = sample_reg[MAG_W-1:0];
    end

    always_comb
    begin
        if (avg_count_reg == '0)
            eff_count = AVG_W'(1);
        else if (avg_count_reg > AVG_MAX)
            eff_count = AVG_MAX;
        else
            eff_count = avg_count_reg;
    end

    // delay from the averaged peak position and the edge position
    always_comb
    begin
        avg_s  = $signed(DCALC_W'(div_quo[POS_W-1:0]));
        e_s    = $signed(DCALC_W'(edge_pos_reg));
        diff_s = avg_s - e_s;
        abs_s  = (diff_s < 0) ? -diff_s : diff_s;
        if (abs_s > HALF_S)
            d_s = W_S - e_s - avg_s;
        else
            d_s = HALF_S + e_s - avg_s;
        if (d_s < 0)
            d_s = '0;
        else if (d_s > DMAX_S)
            d_s = DMAX_S;
    end

    assign resync_inc = {1'b0, resync_count_reg} + (RESYNC_W + 1)'(1);

    always_comb
    begin
        state_next        = state_reg;
        synced_next       = synced_reg;
        window_count_next = window_count_reg;
        windows_done_next = windows_done_reg;
        window_peak_next  = window_peak_reg;
        peak_pos_next     = peak_pos_reg;
        position_sum_next = position_sum_reg;
        edge_pos_next     = edge_pos_reg;
        delay_next        = delay_reg;
        resync_count_next = resync_count_reg;
        history_next      = history_reg;
        mag_next          = mag_reg;
        lock_c            = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                    state_next = S_CALC;
            end
            S_CALC:
            begin
                mag_next     = mag_c;
                history_next = {history_reg[HISTORY_DEPTH-2:0], level_reg};
                if (!synced_reg)
                begin
                    if (level_reg != history_reg[0])
                        edge_pos_next = window_count_reg;
                    if (window_count_reg < WIN_END)
                    begin
                        if (window_count_reg == '0 || mag_c >= window_peak_reg)
                        begin
                            window_peak_next = mag_c;
                            peak_pos_next    = window_count_reg[POS_W-1:0];
                        end
                        window_count_next = window_count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        position_sum_next = position_sum_reg + SUM_W'(peak_pos_reg);
                        windows_done_next = windows_done_reg + WD_W'(1);
                        window_count_next = '0;
                    end
                    lock_c = AVG_W'(windows_done_next) >= eff_count;
                end
                else
                begin
                    if (resync_inc > {1'b0, resync_interval_reg})
                    begin
                        synced_next       = 1'b0;
                        resync_count_next = '0;
                    end
                    else
                        resync_count_next = resync_inc[RESYNC_W-1:0];
                end
                state_next = lock_c ? S_DSTART : S_OUT;
            end
            S_DSTART:
            begin
                state_next = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (div_status.done)
                    state_next = S_DELAY;
            end
            S_DELAY:
            begin
                delay_next        = DELAY_W'(d_s);
                synced_next       = 1'b1;
                windows_done_next = '0;
                position_sum_next = '0;
                state_next        = S_OUT;
            end
            S_OUT:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (result_ch.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_IDLE;
            avg_count_reg       <= AVG_COUNT_RESET;
            resync_interval_reg <= RESYNC_INTERVAL_RESET;
            synced_reg          <= 1'b0;
            window_count_reg    <= '0;
            windows_done_reg    <= '0;
            window_peak_reg     <= '0;
            peak_pos_reg        <= '0;
            position_sum_reg    <= '0;
            edge_pos_reg        <= '0;
            delay_reg           <= '0;
            resync_count_reg    <= '0;
            history_reg         <= '0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            synced_reg       <= synced_next;
            window_count_reg <= window_count_next;
            windows_done_reg <= windows_done_next;
            window_peak_reg  <= window_peak_next;
            peak_pos_reg     <= peak_pos_next;
            position_sum_reg <= position_sum_next;
            edge_pos_reg     <= edge_pos_next;
            delay_reg        <= delay_next;
            resync_count_reg <= resync_count_next;
            history_reg      <= history_next;
            out_valid_reg    <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_AVG_COUNT:       avg_count_reg       <= cfg_data[AVG_W-1:0];
                    REG_RESYNC_INTERVAL: resync_interval_reg <= cfg_data[RESYNC_W-1:0];
                    default:             ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        if (in_take)
        begin
            sample_reg <= sample_ch.sample;
            level_reg  <= sample_ch.clock_level;
        end
        if (out_load)
        begin
            out_mag_reg    <= mag_reg;
            out_clk_reg    <= history_reg[delay_reg];
            out_locked_reg <= synced_reg;
            out_delay_reg  <= delay_reg;
        end
    end

    assign result_ch.valid         = out_valid_reg;
    assign result_ch.magnitude     = out_mag_reg;
    assign result_ch.aligned_clock = out_clk_reg;
    assign result_ch.locked        = out_locked_reg;
    assign result_ch.clock_delay   = out_delay_reg;

endmodule

### rtl/acpa_checker.sv
module acpa_checker
    import acpa_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [MAG_W-1:0]   out_magnitude,
    input logic [DELAY_W-1:0] out_delay
);

    // stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_magnitude) && $stable(out_delay))
    else $error("stalled result word changed");

    // one sample word in flight at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("input taken while previous word in progress");

    // delay stays inside the history line
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_delay <= DELAY_W'(HISTORY_DEPTH - 1))
    else $error("clock delay beyond history depth");

    // a result word does not rise directly after a sample is accepted
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("result word without processing latency");

endmodule

bind argmax_clock_phase_aligner_top acpa_checker u_acpa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (sample_ch.valid),
    .in_ready      (sample_ch.ready),
    .out_valid     (result_ch.valid),
    .out_ready     (result_ch.ready),
    .out_magnitude (result_ch.magnitude),
    .out_delay     (result_ch.clock_delay)
);
